// ===== sv/dqd_pkg.sv =====
// ----------------------------------------------------------------------------
// dqd_pkg
// Shared types and constants for the deque-with-delete unit: field widths,
// request codes, status codes and default sizing.
// ----------------------------------------------------------------------------
package dqd_pkg;

  localparam int REQ_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int DOUT_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_COUNT      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== sv/dqd_if.sv =====
// ----------------------------------------------------------------------------
// dqd_req_if / dqd_res_if
// Valid/ready channels for requests into and results out of the deque unit.
// ----------------------------------------------------------------------------
interface dqd_req_if;
  import dqd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface dqd_res_if;
  import dqd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DOUT_W-1:0]  data_out;
  logic [COUNT_W-1:0]        count;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, output data_out, output count, output status, input ready);
  modport sink   (input valid, input data_out, input count, input status, output ready);
endinterface

// ===== sv/dqd_mem.sv =====
// ----------------------------------------------------------------------------
// dqd_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dqd_mem #(
  parameter int DEPTH      = dqd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqd_pkg::DATA_WIDTH_DEF,
  parameter int IDX_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [IDX_W-1:0]      raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/dqd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqd_ctrl
// Request sequencer: front index and occupancy, memory access scheduling,
// pipelined scan/compact for delete, and the result register.
// ----------------------------------------------------------------------------
module dqd_ctrl #(
  parameter int DEPTH      = dqd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqd_pkg::DATA_WIDTH_DEF,
  parameter int IDX_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dqd_req_if.sink               in_req,
  dqd_res_if.source             out_res,
  output logic                  mem_we,
  output logic [IDX_W-1:0]      mem_waddr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output logic                  mem_re,
  output logic [IDX_W-1:0]      mem_raddr,
  input  logic [DATA_WIDTH-1:0] mem_rdata
);
  import dqd_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]            state_r,  state_nxt;
  logic [REQ_W-1:0]      req_r,    req_nxt;
  logic [DATA_WIDTH-1:0] val_r,    val_nxt;
  logic [IDX_W-1:0]      front_r,  front_nxt;
  logic [CNT_W-1:0]      occ_r,    occ_nxt;
  logic [CNT_W-1:0]      rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0]      pos_r,    pos_nxt;
  logic                  rv_r,     rv_nxt;
  logic [DOUT_W-1:0]     res_data_r,   res_data_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic                  out_valid_r,  out_valid_nxt;
  logic [DOUT_W-1:0]     out_data_r,   out_data_nxt;
  logic [COUNT_W-1:0]    out_count_r,  out_count_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  logic [DATA_WIDTH-1:0] val_in;
  logic [DOUT_W-1:0]     rdata_ext;
  logic [COUNT_W-1:0]    occ_out;
  logic                  full, empty, match;
  logic [IDX_W-1:0]      front_dec, front_inc;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(pos);
    if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
    return sum[IDX_W-1:0];
  endfunction

  // width adaption of the fixed 32-bit fields to DATA_WIDTH, and of the occupancy to the 5-bit count field
  generate
    if (DATA_WIDTH <= VALUE_W) begin : g_val_cut
      assign val_in = in_req.value[DATA_WIDTH-1:0];
    end else begin : g_val_ext
      assign val_in = {{(DATA_WIDTH-VALUE_W){in_req.value[VALUE_W-1]}}, in_req.value};
    end
    if (DATA_WIDTH >= DOUT_W) begin : g_out_cut
      assign rdata_ext = mem_rdata[DOUT_W-1:0];
    end else begin : g_out_ext
      assign rdata_ext = {{(DOUT_W-DATA_WIDTH){mem_rdata[DATA_WIDTH-1]}}, mem_rdata};
    end
    if (CNT_W >= COUNT_W) begin : g_cnt_cut
      assign occ_out = occ_nxt[COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign occ_out = COUNT_W'(occ_nxt);
    end
  endgenerate

  assign full      = (occ_r == CNT_W'(DEPTH));
  assign empty     = (occ_r == '0);
  assign match     = rv_r && (mem_rdata == val_r);
  assign front_dec = (front_r == '0) ? IDX_W'(DEPTH - 1) : front_r - IDX_W'(1);
  assign front_inc = (front_r == IDX_W'(DEPTH - 1)) ? '0 : front_r + IDX_W'(1);

  assign in_req.ready     = (state_r == S_IDLE);
  assign out_res.valid    = out_valid_r;
  assign out_res.data_out = out_data_r;
  assign out_res.count    = out_count_r;
  assign out_res.status   = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    val_nxt        = val_r;
    front_nxt      = front_r;
    occ_nxt        = occ_r;
    rd_pos_nxt     = rd_pos_r;
    pos_nxt        = pos_r;
    rv_nxt         = rv_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = front_r;
    mem_wdata      = val_r;
    mem_re         = 1'b0;
    mem_raddr      = slot_of(front_r, rd_pos_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          req_nxt   = in_req.req_type;
          val_nxt   = val_in;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_data_nxt   = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_FIN;
        unique case (req_r)
          REQ_PUSH_BACK: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = slot_of(front_r, occ_r);
              occ_nxt   = occ_r + CNT_W'(1);
            end
          end
          REQ_PUSH_FRONT: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = front_dec;
              front_nxt = front_dec;
              occ_nxt   = occ_r + CNT_W'(1);
            end
          end
          REQ_POP_BACK: begin
            if (empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = slot_of(front_r, occ_r - CNT_W'(1));
              occ_nxt   = occ_r - CNT_W'(1);
              state_nxt = S_RDWAIT;
            end
          end
          REQ_POP_FRONT: begin
            if (empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = front_r;
              front_nxt = front_inc;
              occ_nxt   = occ_r - CNT_W'(1);
              state_nxt = S_RDWAIT;
            end
          end
          REQ_DELETE: begin
            rd_pos_nxt = '0;
            rv_nxt     = 1'b0;
            state_nxt  = S_SCAN;
          end
          default: ;  // count and unused codes
        endcase
      end
      S_RDWAIT: begin
        res_data_nxt = rdata_ext;
        state_nxt    = S_FIN;
      end
      S_SCAN, S_SHIFT: begin
        // one read in flight: data at pos_r arrives while rd_pos_r is issued
        rv_nxt = 1'b0;
        if (rd_pos_r < occ_r) begin
          mem_re     = 1'b1;
          rd_pos_nxt = rd_pos_r + CNT_W'(1);
          pos_nxt    = rd_pos_r;
          rv_nxt     = 1'b1;
        end
        if (state_r == S_SHIFT) begin
          // move each later entry down by one slot
          if (rv_r) begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(front_r, pos_r - CNT_W'(1));
            mem_wdata = mem_rdata;
          end
          if (rd_pos_r == occ_r) begin
            occ_nxt   = occ_r - CNT_W'(1);
            state_nxt = S_FIN;
          end
        end else if (match) begin
          if (rd_pos_r == occ_r) begin
            occ_nxt   = occ_r - CNT_W'(1);
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else if (rd_pos_r == occ_r) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_count_nxt  = occ_out;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    val_r        <= val_nxt;
    rd_pos_r     <= rd_pos_nxt;
    pos_r        <= pos_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ===== sv/deque_with_delete_unit.sv =====
// ----------------------------------------------------------------------------
// deque_with_delete_unit
// Bounded double-ended queue with delete-first-match, built on one entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : valid/ready request channel (req_type, value). A request is
//             taken when valid and ready are both high; one request is
//             worked on at a time.
//   out_res : valid/ready result channel (data_out, count, status), exactly
//             one result per request, in request order.
//   Steps, accept to result valid: push and count pass the execute and finish
//   states; pop adds a wait for the read data; delete makes one RAM read per
//   entry scanned or moved, pipelined against the RAM's registered read.
//   Acceptance: a new request is taken once the previous one has reached
//   the output register.
//   Reset: synchronous, active low; the queue comes up empty with the front
//   index at slot 0. The entry RAM itself is not cleared.
//   Receiver stall: the result waits in the output register; the next
//   request is still taken and executed, then holds until the register frees.
// ----------------------------------------------------------------------------
module deque_with_delete_unit #(
  parameter int DEPTH      = dqd_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqd_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dqd_req_if.sink   in_req,
  dqd_res_if.source out_res
);
  import dqd_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  dqd_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  dqd_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== sv/dqd_checker.sv =====
// ----------------------------------------------------------------------------
// dqd_port_checker
// Port-level checks on the deque unit, bound to the top level.
// ----------------------------------------------------------------------------
module dqd_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [dqd_pkg::DOUT_W-1:0]      out_data_out,
  input logic [dqd_pkg::COUNT_W-1:0]     out_count,
  input logic [dqd_pkg::STATUS_W-1:0]    out_status
);
  import dqd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out) &&
                                $stable(out_count) && $stable(out_status))
    else $error("result changed while stalled");

  // one request at a time: ready drops right after a request is taken
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // only a successful pop carries data
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_data_out == '0)
    else $error("data on a failed request");

  // an empty report means nothing is held
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind deque_with_delete_unit dqd_port_checker u_dqd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .out_data_out (out_res.data_out),
  .out_count    (out_res.count),
  .out_status   (out_res.status)
);
